>>> design/isq_pkg.sv
`default_nettype none

package isq_pkg;

  localparam int DATA_W           = 32;
  localparam int POS_W            = 8;
  localparam int OP_W             = 3;
  localparam int STATUS_W         = 2;
  localparam int COUNT_OUT_W      = 7;
  localparam int DEFAULT_CAPACITY = 64;
  // cells per first-level group of the read reduction
  localparam int GROUP_SIZE       = 8;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_AT     = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // broadcast from the control to every cell of the row
  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/isq_if.sv
`default_nettype none

interface isq_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [isq_pkg::OP_W-1:0]      operation;
  logic [isq_pkg::POS_W-1:0]     position;
  logic signed [isq_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface isq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [isq_pkg::DATA_W-1:0] read_value;
  logic [isq_pkg::STATUS_W-1:0]      status;
  logic [isq_pkg::COUNT_OUT_W-1:0]   element_count;

  modport source (output valid, output read_value, output status,
                  output element_count, input ready);
  modport sink   (input valid, input read_value, input status,
                  input element_count, output ready);
endinterface

`default_nettype wire

>>> design/isq_cell.sv
`default_nettype none

module isq_cell #(
  parameter int INDEX = 0,
  parameter int PW    = isq_pkg::POS_W
) (
  input  wire logic                        clk,
  input  wire isq_pkg::cell_cmd_t          cmd,
  input  wire logic [PW-1:0]               position,
  input  wire logic [isq_pkg::DATA_W-1:0]  left,
  input  wire logic [isq_pkg::DATA_W-1:0]  right,
  output logic      [isq_pkg::DATA_W-1:0]  data,
  output logic      [isq_pkg::DATA_W-1:0]  hit
);
  import isq_pkg::*;

  localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

  // take the left neighbor behind an insert point, the right one from a delete point on
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (MY_INDEX > position) begin
          data <= left;
        end else if (MY_INDEX == position) begin
          data <= cmd.value;
        end
      end
      CELL_DELETE: begin
        if (MY_INDEX >= position) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

  // drive own word onto the read reduction only when addressed
  assign hit = (MY_INDEX == position) ? data : '0;

endmodule

`default_nettype wire

>>> design/indexed_sequence_store_unit.sv
`default_nettype none
// Ordered store of signed 32-bit words held in a row of CAPACITY shifting cells.
// Requests are registered into a pending stage, then into the response register,
// which holds while the response port stalls. Throughput: one request per cycle
// unless the response port stalls; insert and delete shift the whole row in the
// accept cycle, and a read goes through a registered two-level OR of the cells.
// Reset clears the count and the response valid; cell contents stay undefined.

module indexed_sequence_store_unit #(
  parameter int CAPACITY = isq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  isq_cmd_if.sink   cmd,
  isq_rsp_if.source rsp
);
  import isq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  // positions are compared at the wider of the request field and the count
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CX_W  = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam int NGRP  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  // control state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pend;
  logic             pend_read;
  status_t          pend_status;
  logic [COUNT_OUT_W-1:0] pend_count;

  // accept-cycle decode
  cell_cmd_t        cell_cmd;
  logic [PW-1:0]    cell_pos;
  status_t          status_next;
  logic             read_ok;
  logic             slot_free;
  logic             accept;
  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    cnt_ext;
  logic [PW-1:0]    ins_pos;
  logic [CX_W-1:0]  count_wide;

  // row of cells and read reduction
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_hit  [CAPACITY];
  logic [DATA_W-1:0] grp       [NGRP];
  logic [DATA_W-1:0] grp_next  [NGRP];
  logic [DATA_W-1:0] read_word;

  // a response slot frees when the output register is empty or being taken
  assign slot_free = !rsp.valid || rsp.ready;
  // hold requests off during reset; take a new request while the pending one
  // moves into the output register
  assign cmd.ready = !rst && (!pend || slot_free);
  assign accept    = cmd.valid && cmd.ready;

  assign pos_ext = PW'(cmd.position);
  assign cnt_ext = PW'(count);

  always_comb begin
    status_next = ST_OK;
    read_ok     = 1'b0;
    count_next  = count;
    ins_pos     = '0;
    cell_pos    = pos_ext;
    cell_cmd.op    = CELL_HOLD;
    cell_cmd.value = DATA_W'(cmd.value);

    unique case (cmd.operation)
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          read_ok = 1'b1;
        end else begin
          status_next = ST_INVALID;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        priority if (cmd.operation == OP_HEAD) begin
          ins_pos = '0;
        end else if (cmd.operation == OP_TAIL) begin
          ins_pos = cnt_ext;
        end else begin
          ins_pos = pos_ext;
        end
        cell_pos = ins_pos;
        // range check first, then capacity
        priority if (ins_pos > cnt_ext) begin
          status_next = ST_INVALID;
        end else if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          cell_cmd.op = CELL_INSERT;
          count_next  = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_ext < cnt_ext) begin
          cell_cmd.op = CELL_DELETE;
          count_next  = count - CNT_W'(1);
        end else begin
          status_next = ST_INVALID;
        end
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase

    // drop the shift unless the request is really taken
    if (!accept) begin
      cell_cmd.op = CELL_HOLD;
    end
  end

  assign count_wide = CX_W'(count_next);

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_in;
      logic [DATA_W-1:0] right_in;
      if (i == 0) begin : g_first
        assign left_in = cell_cmd.value;
      end else begin : g_left
        assign left_in = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_in = cell_data[i];
      end else begin : g_right
        assign right_in = cell_data[i+1];
      end
      isq_cell #(
        .INDEX (i),
        .PW    (PW)
      ) u_cell (
        .clk      (clk),
        .cmd      (cell_cmd),
        .position (cell_pos),
        .left     (left_in),
        .right    (right_in),
        .data     (cell_data[i]),
        .hit      (cell_hit[i])
      );
    end
  endgenerate

  // first level: OR the addressed cell's word within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | cell_hit[g * GROUP_SIZE + k];
        end
      end
    end
  end

  // second level: OR the registered group words
  always_comb begin
    read_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      read_word = read_word | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp         <= grp_next;
      pend_read   <= read_ok;
      pend_status <= status_next;
      pend_count  <= count_wide[COUNT_OUT_W-1:0];
    end
    if (pend && slot_free) begin
      rsp.read_value    <= pend_read ? $signed(read_word) : '1;
      rsp.status        <= pend_status;
      rsp.element_count <= pend_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      // hold the pending request until the output register frees
      if (accept) begin
        pend <= 1'b1;
      end else if (slot_free) begin
        pend <= 1'b0;
      end
      if (slot_free) begin
        rsp.valid <= pend;
      end
    end
  end

endmodule

`default_nettype wire
